[hdl/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types, constants and binary-to-BCD helpers for the signed integer
// to decimal text converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int VALUE_W         = 32;
	localparam int NUM_DIGITS      = 10;
	localparam int BCD_W           = 4 * NUM_DIGITS;
	localparam int DIGIT_IDX_W     = $clog2(NUM_DIGITS);
	localparam int CHAR_W          = 6;
	localparam int STEPS_PER_STAGE = 8;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

	// Data carried down the conversion pipeline.
	typedef struct packed {
		logic [BCD_W-1:0]   bcd;
		logic [VALUE_W-1:0] bin;
		logic               neg;
	} conv_t;

	// One double-dabble step: correct every digit, then shift in one bit.
	function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
			input logic bit_in);
		logic [BCD_W-1:0] adj;
		logic [3:0]       nib;
		adj = bcd;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			nib = bcd[i*4 +: 4];
			if (nib >= 4'd5) begin
				nib = nib + 4'd3;
			end
			adj[i*4 +: 4] = nib;
		end
		return {adj[BCD_W-2:0], bit_in};
	endfunction

	// The share of the conversion done by one pipeline stage.
	function automatic conv_t dd_stage(input conv_t c);
		conv_t r;
		r = c;
		for (int s = 0; s < STEPS_PER_STAGE; s++) begin
			r.bcd = dd_step(r.bcd, r.bin[VALUE_W-1]);
			r.bin = {r.bin[VALUE_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

[hdl/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer into its decimal ASCII text, one
// character per cycle, sign first, most significant digit first.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake        Payload                 Direction
//   -------   --------------   ---------------------   ---------
//   input     start / busy     value                   in
//   result    strobe           ascii_char, last_char   out
//
// An item is taken on a clock edge with start high and busy low. It passes
// one stage that forms sign and magnitude and four stages of eight
// double-dabble steps each, then loads the character serializer, whose
// registers drive the first character; each item then occupies the result
// port for 1 to 11 characters (sign plus digits), one character a cycle,
// which sets the sustained rate. Reset clears all valid bits and the
// serializer. The receiver cannot stall; busy rises while the last pipeline
// stage holds an item that the serializer cannot take yet.
//
module signed_int_to_decimal_ascii
	import sitda_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [VALUE_W-1:0] value,
	output logic                     strobe,
	output logic [CHAR_W-1:0]        ascii_char,
	output logic                     last_char
);

	logic  v_s1, v_s2, v_s3, v_s4, v_s5;
	conv_t conv_s1, conv_s2, conv_s3, conv_s4, conv_s5;

	logic                   act_q;
	logic                   sign_q;
	logic [DIGIT_IDX_W-1:0] idx_q;
	logic [BCD_W-1:0]       bcd_q;

	logic                   last_now;
	logic                   ser_free;
	logic                   load;
	logic                   en;
	logic [VALUE_W-1:0]     raw;
	logic [VALUE_W-1:0]     mag;
	logic [DIGIT_IDX_W-1:0] top_idx;
	logic [3:0]             cur_digit;

	assign raw = $unsigned(value);
	assign mag = raw[VALUE_W-1] ? VALUE_W'(~raw + 32'd1) : raw;

	assign last_now = act_q && !sign_q && (idx_q == '0);
	assign ser_free = !act_q || last_now;
	assign load     = v_s5 && ser_free;
	assign en       = !v_s5 || ser_free;
	assign busy     = !en;

	// Index of the most significant nonzero digit; zero prints one digit.
	always_comb begin
		top_idx = '0;
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (conv_s5.bcd[i*4 +: 4] != 4'd0) begin
				top_idx = DIGIT_IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			conv_s1.bcd <= '0;
			conv_s1.bin <= mag;
			conv_s1.neg <= raw[VALUE_W-1];
			conv_s2     <= dd_stage(conv_s1);
			conv_s3     <= dd_stage(conv_s2);
			conv_s4     <= dd_stage(conv_s3);
			conv_s5     <= dd_stage(conv_s4);
		end
	end

	// Serializer: the sign goes out first, then digits from the top index down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			sign_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			act_q  <= 1'b1;
			sign_q <= conv_s5.neg;
			idx_q  <= top_idx;
		end else if (act_q) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else if (idx_q == '0) begin
				act_q <= 1'b0;
			end else begin
				idx_q <= idx_q - DIGIT_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= conv_s5.bcd;
		end
	end

	assign cur_digit  = bcd_q[{idx_q, 2'b00} +: 4];
	assign strobe     = act_q;
	assign ascii_char = sign_q ? CHAR_MINUS : CHAR_ZERO + {2'b00, cur_digit};
	assign last_char  = last_now;

endmodule

[tb/signed_int_to_decimal_ascii_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test
// Self-checking bench for the integer to decimal text converter. A driver
// presents queued integers on the start/busy port. A behavioral model turns
// each accepted item into its expected character run. A monitor compares
// every strobed character and its last flag against that run in order.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;
	import sitda_pkg::*;

	typedef struct {
		logic [VALUE_W-1:0] value;
		int unsigned        idle_pct;
		bit                 drain;
	} number_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_char_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      busy;
	logic                      strobe;
	logic [CHAR_W-1:0]         ascii_char;
	logic                      last_char;

	number_item_t pending_numbers[$];
	text_char_t   expected_text[$];
	int unsigned  mismatches = 0;

	signed_int_to_decimal_ascii i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.strobe     (strobe),
		.ascii_char (ascii_char),
		.last_char  (last_char)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Appends the decimal text of one integer to the expected character run.
	function automatic void predict_text(input logic [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] mag;
		logic [3:0]         digits[NUM_DIGITS];
		int                 ndig;
		text_char_t         c;
		mag  = v[VALUE_W-1] ? (~v + 1'b1) : v;
		ndig = 0;
		do begin
			digits[ndig] = 4'(mag % 10);
			mag = mag / 10;
			ndig++;
		end while (mag != 0 && ndig < NUM_DIGITS);
		if (v[VALUE_W-1]) begin
			c.ch   = CHAR_MINUS;
			c.last = 1'b0;
			expected_text.push_back(c);
		end
		for (int k = ndig - 1; k >= 0; k--) begin
			c.ch   = CHAR_ZERO + CHAR_W'(digits[k]);
			c.last = (k == 0);
			expected_text.push_back(c);
		end
	endfunction

	// Mixes full-width words with values of a chosen digit count, so that
	// short runs and the ten-digit edges both show up often.
	function automatic logic [VALUE_W-1:0] random_number();
		logic [VALUE_W-1:0] mag;
		int unsigned        lo;
		int unsigned        hi;
		int unsigned        ndig;
		mag = '0;
		case ($urandom_range(0, 5))
			0: mag = $urandom;
			1, 2, 3: begin
				ndig = $urandom_range(1, 10);
				lo = 1;
				for (int i = 1; i < ndig; i++) begin
					lo = lo * 10;
				end
				hi = (ndig == 10) ? 32'd2147483648 : lo * 10 - 1;
				if (ndig == 1) begin
					lo = 0;
				end
				mag = $urandom_range(lo, hi);
			end
			4: mag = 32'd2147483648 - $urandom_range(0, 20);
			default: begin
				mag = 1;
				ndig = $urandom_range(0, 9);
				for (int i = 0; i < ndig; i++) begin
					mag = mag * 10;
				end
				mag = mag + $urandom_range(0, 2) - 1;
			end
		endcase
		return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
	endfunction

	function automatic void queue_number(input logic [VALUE_W-1:0] v,
			input int unsigned idle_pct, input bit drain);
		number_item_t it;
		it.value    = v;
		it.idle_pct = idle_pct;
		it.drain    = drain;
		pending_numbers.push_back(it);
	endfunction

	// Driver: on acceptance the item is predicted and retired, then the next
	// one is offered unless the sender chooses to idle or must drain first.
	always @(posedge clk) begin : drive_numbers
		logic accepted;
		logic offer;
		logic hold;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			accepted = start && !busy;
			if (accepted) begin
				predict_text(value);
				void'(pending_numbers.pop_front());
			end
			offer = 1'b0;
			if (pending_numbers.size() > 0) begin
				if (start && !accepted) begin
					offer = 1'b1;
				end else begin
					hold  = pending_numbers[0].drain && expected_text.size() > 0;
					offer = !hold &&
						($urandom_range(0, 99) >= pending_numbers[0].idle_pct);
				end
			end
			start <= offer;
			if (offer) begin
				value <= pending_numbers[0].value;
			end
		end
	end

	always @(posedge clk) begin : check_text
		text_char_t exp_c;
		if (arst_n && strobe) begin
			if (expected_text.size() == 0) begin
				report_mismatch($sformatf("unexpected character %0d last %0b",
					ascii_char, last_char));
			end else begin
				exp_c = expected_text.pop_front();
				if (ascii_char !== exp_c.ch) begin
					report_mismatch($sformatf("ascii_char %0d, expected %0d",
						ascii_char, exp_c.ch));
				end
				if (last_char !== exp_c.last) begin
					report_mismatch($sformatf("last_char %0b, expected %0b",
						last_char, exp_c.last));
				end
			end
		end
	end

	initial begin
		logic [VALUE_W-1:0] directed[$];
		directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99,
			32'd100, -32'sd100, 32'd2147483647, 32'h8000_0000, -32'sd2147483647,
			32'd1000000000, 32'd999999999, -32'sd999999999, 32'd1234567890,
			-32'sd1234567890, 32'd4294967, -32'sd7, 32'h5555_5555, 32'hAAAA_AAAA,
			32'd1000000001, -32'sd1000000000};
		foreach (directed[i]) begin
			queue_number(directed[i], 17, 1'b0);
		end
		for (int i = 0; i < 100; i++) begin
			queue_number(random_number(), 17, $urandom_range(0, 29) == 0);
		end
		// The sender holds back at the start of this phase and the next until the block is empty.
		for (int i = 0; i < 110; i++) begin
			queue_number(random_number(), 75, i == 0 || $urandom_range(0, 29) == 0);
		end
		for (int i = 0; i < 110; i++) begin
			queue_number(random_number(), 0, i == 0 || $urandom_range(0, 29) == 0);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_numbers.size() != 0 || expected_text.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_text.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
